// ----- hdl/vzc_pkg.sv -----
package vzc_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned NARROW_W   = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned GROUP_W    = 7;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned S_TUSER_W  = 3;
    localparam int unsigned M_TDATA_W  = 72;
    localparam int unsigned M_TUSER_W  = 2;

    localparam logic [COUNT_W-1:0] NARROW_MAX_BYTES = 4'd5;
    localparam logic [COUNT_W-1:0] WIDE_MAX_BYTES   = 4'd10;

    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;

    // Operation codes carried in the lowest tuser bit of an input item.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic enc_load;   // capture and zigzag-map a value for encoding
        logic enc_emit;   // push the next encoded byte to the output register
        logic dec_step;   // fold one byte into the accumulator
        logic dec_emit;   // push the decoded value to the output register
    } vzc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;   // output register can take an item this cycle
        logic enc_final;  // the remaining value fits in one byte
        logic dec_done;   // the byte at the input completes a value
    } vzc_status_t;

endpackage

// ----- hdl/varint_zigzag_codec.sv -----
// Decode: one byte per cycle while s_tready is high; a completed value is registered onto m_*.
// Encode: the value item is captured in the encode shift register, then one byte per cycle
//   leaves it while the output is free; no new item is taken before the final byte is emitted.
// One output register: a new result enters as the waiting one leaves; m_tready low stalls all.
// Reset (aresetn low, synchronous) clears the decode accumulator and byte count, empties the
//   output register and returns the controller to idle.
module varint_zigzag_codec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vzc_pkg::S_TDATA_W-1:0] s_tdata,   // value_in[63:0], byte_in[71:64]
    input  logic [vzc_pkg::S_TUSER_W-1:0] s_tuser,   // cmd[0], wide[1], signed_zigzag[2]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vzc_pkg::M_TDATA_W-1:0] m_tdata,   // byte_out[7:0], value_out[71:8]
    output logic [vzc_pkg::M_TUSER_W-1:0] m_tuser,   // byte_valid[0], value_valid[1]
    output logic                          m_tlast    // last byte of an encoding, or a value
);
    import vzc_pkg::*;

    vzc_cmd_t    cmd;
    vzc_status_t status;

    // Controller: sequences item acceptance and the byte-by-byte encode drain.
    vzc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: zigzag mapping, encode shift register, decode accumulator
    // and the output register.
    vzc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/vzc_ctrl.sv -----
module vzc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                in_cmd,
    output logic                s_tready,
    input  vzc_pkg::vzc_status_t status,
    output vzc_pkg::vzc_cmd_t   cmd
);
    import vzc_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_ENCODE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_DECODE) begin
                        cmd.dec_step = 1'b1;
                        cmd.dec_emit = status.dec_done;
                    end else begin
                        cmd.enc_load = 1'b1;
                        state_next   = ST_ENCODE;
                    end
                end
            end
            ST_ENCODE: begin
                // Emit one byte per free output slot; return on the final byte.
                if (status.out_free) begin
                    cmd.enc_emit = 1'b1;
                    if (status.enc_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/vzc_datapath.sv -----
module vzc_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [vzc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [vzc_pkg::S_TUSER_W-1:0]      s_tuser,
    input  vzc_pkg::vzc_cmd_t                  cmd,
    output vzc_pkg::vzc_status_t               status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vzc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [vzc_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast
);
    import vzc_pkg::*;

    logic                 in_wide;
    logic                 in_zz;
    logic [VALUE_W-1:0]   in_value;
    logic [BYTE_W-1:0]    in_byte;
    logic [VALUE_W-1:0]   width_mask;

    logic [VALUE_W-1:0]   enc_shift_reg;
    logic [VALUE_W-1:0]   enc_shift_next;
    logic [VALUE_W-1:0]   enc_masked;
    logic                 enc_top;
    logic [VALUE_W-1:0]   enc_mapped;

    logic [VALUE_W-1:0]   dec_accum_reg;
    logic [VALUE_W-1:0]   dec_accum_next;
    logic [COUNT_W-1:0]   dec_count_reg;
    logic [COUNT_W-1:0]   dec_count_next;
    logic [COUNT_W-1:0]   dec_count_inc;
    logic [COUNT_W-1:0]   dec_limit;
    logic [5:0]           dec_shamt;
    logic [VALUE_W-1:0]   dec_group;
    logic [VALUE_W-1:0]   dec_sum;
    logic [VALUE_W-1:0]   dec_trunc;
    logic [VALUE_W-1:0]   dec_value;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [BYTE_W-1:0]    out_byte_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VALUE_W-1:0]   out_value_next;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic [M_TUSER_W-1:0] out_user_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_byte  = s_tdata[VALUE_W +: BYTE_W];
    assign in_wide  = s_tuser[1];
    assign in_zz    = s_tuser[2];

    assign width_mask = in_wide ? {VALUE_W{1'b1}} : {{(VALUE_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};

    // Encode: truncate, then zigzag-map when signed.
    assign enc_masked = in_value & width_mask;
    assign enc_top    = in_wide ? enc_masked[VALUE_W-1] : enc_masked[NARROW_W-1];
    assign enc_mapped = in_zz ? (((enc_masked << 1) ^ {VALUE_W{enc_top}}) & width_mask)
                              : enc_masked;

    assign status.enc_final = (enc_shift_reg[VALUE_W-1:GROUP_W] == '0);

    // Decode: group offset is 7 * count, count never exceeds 9.
    // 8 * count - count, taken modulo 64, covers counts 8 and 9 as well.
    assign dec_shamt     = {dec_count_reg[2:0], 3'b000} - {2'b00, dec_count_reg};
    assign dec_group     = {{(VALUE_W-GROUP_W){1'b0}}, in_byte[GROUP_W-1:0]} << dec_shamt;
    assign dec_sum       = dec_accum_reg | dec_group;
    assign dec_count_inc = dec_count_reg + 4'd1;
    assign dec_limit     = in_wide ? WIDE_MAX_BYTES : NARROW_MAX_BYTES;
    assign status.dec_done = ((in_byte & CONT_BIT) == '0) || (dec_count_inc >= dec_limit);

    assign dec_trunc = dec_sum & width_mask;
    assign dec_value = in_zz ? (((dec_trunc >> 1) ^ {VALUE_W{dec_trunc[0]}}) & width_mask)
                             : dec_trunc;

    assign status.out_free = !out_valid_reg || m_tready;

    always_comb begin
        enc_shift_next = enc_shift_reg;
        dec_accum_next = dec_accum_reg;
        dec_count_next = dec_count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_value_next = out_value_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        if (cmd.enc_load) begin
            enc_shift_next = enc_mapped;
        end
        if (cmd.enc_emit) begin
            enc_shift_next = enc_shift_reg >> GROUP_W;
            out_valid_next = 1'b1;
            out_byte_next  = {!status.enc_final, enc_shift_reg[GROUP_W-1:0]};
            out_value_next = '0;
            out_user_next  = 2'b01;
            out_last_next  = status.enc_final;
        end
        if (cmd.dec_step) begin
            if (status.dec_done) begin
                dec_accum_next = '0;
                dec_count_next = '0;
            end else begin
                dec_accum_next = dec_sum;
                dec_count_next = dec_count_inc;
            end
        end
        if (cmd.dec_emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_value_next = dec_value;
            out_user_next  = 2'b10;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            dec_accum_reg <= '0;
            dec_count_reg <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            dec_accum_reg <= dec_accum_next;
            dec_count_reg <= dec_count_next;
        end
        enc_shift_reg <= enc_shift_next;
        out_byte_reg  <= out_byte_next;
        out_value_reg <= out_value_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_byte_reg};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/vzc_checker.sv -----
module vzc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vzc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [vzc_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import vzc_pkg::*;

    // A stalled item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Each result is either an encoded byte or a decoded value.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tuser))
        else $error("result kind flags not one-hot");

    // Continuation bit is set exactly on non-final encoded bytes.
    a_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[7] != m_tlast) && (m_tdata[71:8] == '0))
        else $error("encoded byte continuation or value field wrong");

    // A decoded value is always final and carries no byte.
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[7:0] == '0))
        else $error("decoded value item malformed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind varint_zigzag_codec vzc_checker u_vzc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vzc_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 275;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 200;   // long output stall to back the block up
    localparam int DRAIN_CYCLES = 20;    // longest encoding is 10 bytes

    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // One item leaving the codec, unpacked.
    typedef struct {
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        last;
        logic [63:0] value_out;
        logic        value_valid;
    } varint_out_t;

    // Directed stimulus row; typed_val is the byte (encode) or value (decode)
    // of the single result, used only where typed is set.
    typedef struct packed {
        logic        cmd;
        logic        wide;
        logic        zz;
        logic [63:0] value;
        logic [7:0]  byte_in;
        logic        typed;
        logic [63:0] typed_val;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // encode extremes, narrow and wide, plain and zigzag
        '{CMD_ENCODE, 1'b0, 1'b0, 64'h0000_0000_0000_0000, 8'h00, 1'b1, 64'h00},
        '{CMD_ENCODE, 1'b0, 1'b0, 64'h0000_0000_0000_007F, 8'hFF, 1'b1, 64'h7F},
        '{CMD_ENCODE, 1'b0, 1'b0, 64'h0000_0000_FFFF_FFFF, 8'h5A, 1'b0, 64'h00},
        '{CMD_ENCODE, 1'b0, 1'b0, 64'hFFFF_FFFF_0000_0001, 8'hA5, 1'b1, 64'h01},
        '{CMD_ENCODE, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 64'h00},
        '{CMD_ENCODE, 1'b0, 1'b1, 64'h0000_0000_FFFF_FFFF, 8'h00, 1'b1, 64'h01},
        '{CMD_ENCODE, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 8'h00, 1'b0, 64'h00},
        '{CMD_ENCODE, 1'b1, 1'b1, 64'h0000_0000_0000_0001, 8'h00, 1'b1, 64'h02},
        // single-byte decodes
        '{CMD_DECODE, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0000_0000_0000_0000, 8'h7F, 1'b1, 64'h7F},
        '{CMD_DECODE, 1'b0, 1'b1, 64'h0000_0000_0000_0000, 8'h01, 1'b1, MASK32},
        // overlong narrow run: completes on the fifth byte, high bits dropped
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'hFF, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'hFF, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'hFF, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'hFF, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'hFF, 1'b0, 64'h00},
        // encode in the middle of a decode leaves the accumulator alone
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0,                     8'h80, 1'b0, 64'h00},
        '{CMD_ENCODE, 1'b0, 1'b0, 64'h0000_0000_1234_5678, 8'h00, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0,                     8'h01, 1'b0, 64'h00},
        // five wide continuation bytes, then a narrow one: limit already reached
        '{CMD_DECODE, 1'b1, 1'b0, 64'h0, 8'h81, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b1, 1'b0, 64'h0, 8'h81, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b1, 1'b0, 64'h0, 8'h81, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b1, 1'b0, 64'h0, 8'h81, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b1, 1'b0, 64'h0, 8'h81, 1'b0, 64'h00},
        '{CMD_DECODE, 1'b0, 1'b0, 64'h0, 8'h80, 1'b0, 64'h00}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Shadow of the decode accumulator.
    logic [63:0] acc_bits  = '0;
    logic [3:0]  acc_bytes = '0;

    varint_out_t step_out   [$];   // results of the item just computed
    varint_out_t varint_due [$];   // results still owed by the block, oldest first

    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int error_count = 0;
    int n_encode    = 0;
    int n_decode    = 0;
    int n_results   = 0;

    varint_zigzag_codec u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Compute the items one input item causes; appends to step_out and
    // advances the accumulator shadow.
    function automatic void varint_step(input logic cmd, input logic wide, input logic zz,
                                        input logic [63:0] value, input logic [7:0] byte_in);
        logic [63:0] mask;
        logic [63:0] v;
        logic [3:0]  cnt;
        logic [3:0]  limit;
        varint_out_t r;
        mask = wide ? ONES64 : MASK32;
        r = '{default: '0};
        if (cmd == CMD_ENCODE) begin
            v = value & mask;
            if (zz) begin
                v = ((v << 1) ^ {64{wide ? v[63] : v[31]}}) & mask;
            end
            r.byte_valid = 1'b1;
            while (v >= {56'd0, CONT_BIT}) begin
                r.byte_out = (v[7:0] & GROUP_MASK) | CONT_BIT;
                r.last     = 1'b0;
                step_out = {step_out, r};
                v = v >> GROUP_W;
            end
            r.byte_out = v[7:0];
            r.last     = 1'b1;
            step_out = {step_out, r};
        end else begin
            limit = wide ? WIDE_MAX_BYTES : NARROW_MAX_BYTES;
            cnt = (acc_bytes > WIDE_MAX_BYTES - 4'd1) ? WIDE_MAX_BYTES - 4'd1 : acc_bytes;
            acc_bits = acc_bits | ({57'd0, byte_in[6:0]} << (GROUP_W * cnt));
            cnt = cnt + 4'd1;
            if (byte_in[7] && cnt < limit) begin
                acc_bytes = cnt;
            end else begin
                v = acc_bits & mask;
                if (zz) begin
                    v = ((v >> 1) ^ {64{v[0]}}) & mask;
                end
                acc_bits      = '0;
                acc_bytes     = '0;
                r.last        = 1'b1;
                r.value_out   = v;
                r.value_valid = 1'b1;
                step_out = {step_out, r};
            end
        end
    endfunction

    // Values with a random number of significant bits, a quarter of them
    // inverted so that signed patterns show up.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0) begin
            v = ~v;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offer one item after a random gap (none in a burst) and hold it until
    // accepted; the results it causes are queued at the accepting edge.
    task automatic send_item(input logic cmd, input logic wide, input logic zz,
                             input logic [63:0] value, input logic [7:0] byte_in,
                             input logic typed, input logic [63:0] typed_val);
        int gap;
        varint_out_t r;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {byte_in, value};
        s_tuser  <= {zz, wide, cmd};
        do @(posedge aclk); while (!s_tready);
        step_out.delete();
        varint_step(cmd, wide, zz, value, byte_in);
        if (typed) begin
            r = '{default: '0};
            r.last = 1'b1;
            if (cmd == CMD_ENCODE) begin
                r.byte_out   = typed_val[7:0];
                r.byte_valid = 1'b1;
            end else begin
                r.value_out   = typed_val;
                r.value_valid = 1'b1;
            end
            varint_due = {varint_due, r};
        end else begin
            foreach (step_out[i]) varint_due = {varint_due, step_out[i]};
        end
        if (cmd == CMD_ENCODE) n_encode++;
        else n_decode++;
    endtask

    // Receiver: random stalls per item outside a sink burst, one long hold when asked.
    initial begin : result_sink
        int wait_n;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                wait_n = sink_burst ? 0 : $urandom_range(0, 10);
                if (wait_n > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
        end
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge aclk) begin : result_check
        varint_out_t got;
        varint_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_out    = m_tdata[7:0];
            got.value_out   = m_tdata[71:8];
            got.byte_valid  = m_tuser[0];
            got.value_valid = m_tuser[1];
            got.last        = m_tlast;
            n_results++;
            if (varint_due.size() == 0) begin
                report_mismatch("result with nothing owed, value_out", got.value_out, '0);
            end else begin
                want = varint_due.pop_front();
                if (got.byte_out !== want.byte_out)
                    report_mismatch("byte_out", {56'd0, got.byte_out}, {56'd0, want.byte_out});
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", {63'd0, got.byte_valid},
                                    {63'd0, want.byte_valid});
                if (got.last !== want.last)
                    report_mismatch("last", {63'd0, got.last}, {63'd0, want.last});
                if (got.value_out !== want.value_out)
                    report_mismatch("value_out", got.value_out, want.value_out);
                if (got.value_valid !== want.value_valid)
                    report_mismatch("value_valid", {63'd0, got.value_valid},
                                    {63'd0, want.value_valid});
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  seq [$];
        logic        w;
        logic        z;
        int          k;
        int          n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].cmd, DIRECTED[i].wide, DIRECTED[i].zz, DIRECTED[i].value,
                      DIRECTED[i].byte_in, DIRECTED[i].typed, DIRECTED[i].typed_val);
        end

        while (n_encode + n_decode < N_DIRECTED + N_RANDOM) begin
            if ($urandom_range(0, 7) == 0) src_burst = !src_burst;
            if (!hold_done && n_encode + n_decode >= N_DIRECTED + 80) begin
                // stall the output and keep pushing long encodings at the input
                hold_req  = 1'b1;
                hold_done = 1'b1;
                repeat (6) send_item(CMD_ENCODE, 1'b1, 1'b0, ONES64, 8'($urandom), 1'b0, '0);
            end
            w = 1'($urandom_range(0, 1));
            z = 1'($urandom_range(0, 1));
            k = $urandom_range(0, 99);
            if (k < 35) begin
                send_item(CMD_ENCODE, w, z, random_value(), 8'($urandom), 1'b0, '0);
            end else if (k < 80) begin
                // well-formed: encode a value, feed its bytes back to the decoder
                step_out.delete();
                varint_step(CMD_ENCODE, w, z, random_value(), '0);
                seq.delete();
                foreach (step_out[i]) seq = {seq, step_out[i].byte_out};
                foreach (seq[i]) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(CMD_ENCODE, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), random_value(),
                                  8'($urandom), 1'b0, '0);
                    send_item(CMD_DECODE, w, z, random_value(), seq[i], 1'b0, '0);
                end
            end else if (k < 90) begin
                // noise: loose bytes with random width and sign
                n = $urandom_range(1, 3);
                repeat (n) send_item(CMD_DECODE, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), random_value(),
                                     8'($urandom), 1'b0, '0);
            end else if (k < 95) begin
                // overlong: continuation bytes up to and past the width limit
                n = $urandom_range(1, 11);
                repeat (n) send_item(CMD_DECODE, w, z, random_value(),
                                     8'($urandom) | CONT_BIT, 1'b0, '0);
            end else begin
                // drop from wide to narrow in the middle of a value
                n = $urandom_range(1, 9);
                repeat (n) send_item(CMD_DECODE, 1'b1, z, random_value(),
                                     8'($urandom) | CONT_BIT, 1'b0, '0);
                send_item(CMD_DECODE, 1'b0, z, random_value(), 8'($urandom), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (varint_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d encode and %0d decode items, %0d result items checked,",
                 n_encode, n_decode, n_results);
        $display("with random gaps on both sides and one %0d-cycle output stall.", HOLD_CYCLES);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/vzc_pkg.sv
hdl/vzc_ctrl.sv
hdl/vzc_datapath.sv
hdl/varint_zigzag_codec.sv
hdl/vzc_checker.sv
test/tb_top.sv
